// File: src/emavt_pkg.sv
// ----------------------------------------------------------------------------
// EMA velocity tracker package
// Shared widths and the request and response words of the serial units.
// ----------------------------------------------------------------------------
package emavt_pkg;

  localparam int unsigned McandW = 64;
  localparam int unsigned MplierW = 33;
  localparam int unsigned ProdW = McandW + MplierW;
  localparam int unsigned MulCntW = 6;

  localparam int unsigned DividendW = 96;
  localparam int unsigned DivisorW = 48;
  localparam int unsigned QuotW = 64;
  localparam int unsigned DivCntW = 7;

  // The multiplier operand is left-aligned: its top nbits bits are used.
  typedef struct packed {
    logic                start;
    logic [McandW-1:0]   mcand;
    logic [MplierW-1:0]  mplier;
    logic [MulCntW-1:0]  nbits;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [ProdW-1:0]  prod;
  } mul_rsp_t;

  // The dividend is left-aligned: its top nbits bits are used.
  typedef struct packed {
    logic                  start;
    logic [DividendW-1:0]  dividend;
    logic [DivisorW-1:0]   divisor;
    logic [DivCntW-1:0]    nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QuotW-1:0]  quot;
  } div_rsp_t;

endpackage

// File: src/emavt_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, most significant
// bit first.
// ----------------------------------------------------------------------------
module emavt_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  emavt_pkg::mul_req_t req_i,
  output emavt_pkg::mul_rsp_t rsp_o
);

  logic [emavt_pkg::ProdW-1:0]   acc_q, acc_d;
  logic [emavt_pkg::McandW-1:0]  mc_q;
  logic [emavt_pkg::MplierW-1:0] mr_q;
  logic [emavt_pkg::MulCntW-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;

  always_comb begin
    acc_d = {acc_q[emavt_pkg::ProdW-2:0], 1'b0};
    if (mr_q[emavt_pkg::MplierW-1]) begin
      acc_d = acc_d + {{(emavt_pkg::ProdW-emavt_pkg::McandW){1'b0}}, mc_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      mc_q   <= '0;
      mr_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        acc_q  <= '0;
        mc_q   <= req_i.mcand;
        mr_q   <= req_i.mplier;
        cnt_q  <= req_i.nbits;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_d;
        mr_q  <= {mr_q[emavt_pkg::MplierW-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == emavt_pkg::MulCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

// File: src/emavt_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module emavt_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  emavt_pkg::div_req_t req_i,
  output emavt_pkg::div_rsp_t rsp_o
);

  logic [emavt_pkg::DividendW-1:0] dq_q;
  logic [emavt_pkg::DivisorW-1:0]  dv_q;
  logic [emavt_pkg::DivisorW-1:0]  rem_q;
  logic [emavt_pkg::QuotW-1:0]     quot_q;
  logic [emavt_pkg::DivCntW-1:0]   cnt_q;
  logic                            busy_q;
  logic                            done_q;
  logic [emavt_pkg::DivisorW:0]    trial;
  logic                            fits;

  assign trial = {rem_q, dq_q[emavt_pkg::DividendW-1]};
  assign fits  = trial >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_q   <= '0;
      dv_q   <= '0;
      rem_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        dq_q   <= req_i.dividend;
        dv_q   <= req_i.divisor;
        rem_q  <= '0;
        quot_q <= '0;
        cnt_q  <= req_i.nbits;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dq_q   <= {dq_q[emavt_pkg::DividendW-2:0], 1'b0};
        // The remainder stays below the divisor, so the top bit drops.
        rem_q  <= fits ? emavt_pkg::DivisorW'(trial - {1'b0, dv_q})
                       : trial[emavt_pkg::DivisorW-1:0];
        quot_q <= {quot_q[emavt_pkg::QuotW-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == emavt_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: src/ema_velocity_tracker_decel_predict.sv
// Products, quotients and the root run on a bit-serial multiplier or divider (one bit per cycle) or a
// two-bit-per-cycle square root, and one word is worked on at a time.
// Reset clears the estimate to zero and loads the default register values.
// ----------------------------------------------------------------------------
// EMA velocity tracker with deceleration predictor
// Blends observed velocity into a running estimate and extrapolates the
// position and velocity of the object at a query time.
// ----------------------------------------------------------------------------
module ema_velocity_tracker_decel_predict (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [47:0] stamp_us_i,
  input  logic [31:0] obs_x_i,
  input  logic [31:0] obs_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pred_x_o,
  output logic [31:0] pred_y_o,
  output logic [31:0] pred_vx_o,
  output logic [31:0] pred_vy_o,
  output logic [31:0] velocity_uncertainty_o,
  output logic [47:0] pred_stamp_us_o
);

  localparam logic [1:0] CfgWeight = 2'd0;
  localparam logic [1:0] CfgDecel = 2'd1;
  localparam logic [1:0] CfgUncBase = 2'd2;
  localparam logic [1:0] CfgUncSlope = 2'd3;

  localparam logic [19:0] UsPerS = 20'd1000000;
  localparam logic [20:0] UsPer2S = 21'd2000000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_OB_START, ST_OB_MULD, ST_OB_DIV, ST_OB_MULW, ST_OB_MULO,
    ST_OB_SUM, ST_OB_RND, ST_QY_START, ST_QY_SQX, ST_QY_SQY, ST_QY_SQRT,
    ST_QY_UNC, ST_QY_MST, ST_QY_DST, ST_QY_MSS, ST_QY_DSS, ST_QY_MAT,
    ST_QY_DAT, ST_QY_MTS, ST_QY_DTS, ST_QY_CL, ST_QY_MCMP, ST_QY_DCMP,
    ST_QY_OUT
  } state_e;

  state_e state_q;

  logic [15:0] weight_q;
  logic [20:0] decel_q;
  logic [31:0] unc_base_q;
  logic [15:0] unc_slope_q;

  logic [31:0] est_x_q, est_y_q, est_vx_q, est_vy_q;
  logic [47:0] est_time_q;

  logic        kind_q;
  logic [47:0] stamp_q;
  logic [31:0] obs_x_q, obs_y_q;

  logic        ax_q;
  logic [47:0] dt_q;
  logic        raw_neg_q;
  logic [47:0] p1_q;
  logic [48:0] p2_q;
  logic [49:0] num_q;

  logic [63:0] sq_q;
  logic [63:0] sq_v_q;
  logic [32:0] sq_rem_q;
  logic [31:0] sq_root_q;
  logic [4:0]  sq_cnt_q;

  logic [31:0] s_q;
  logic [47:0] t_q;
  logic [20:0] a_q;
  logic [31:0] speed_q;
  logic [63:0] dist_q;
  logic [1:0]  cidx_q;
  logic [31:0] unc_q;
  logic [31:0] res_x_q, res_y_q, res_vx_q, res_vy_q;

  logic        out_valid_q;
  logic [31:0] out_x_q, out_y_q, out_vx_q, out_vy_q, out_unc_q;
  logic [47:0] out_stamp_q;

  emavt_pkg::mul_req_t mul_req_q;
  emavt_pkg::mul_rsp_t mul_rsp;
  emavt_pkg::div_req_t div_req_q;
  emavt_pkg::div_rsp_t div_rsp;

  logic mul_start_d, div_start_d;

  emavt_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req_q),
    .rsp_o  (mul_rsp)
  );

  emavt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  function automatic logic [31:0] sat_s36(input logic [35:0] v);
    logic [31:0] r;
    r = v[31:0];
    if (!v[35] && (v[34:31] != 4'h0)) begin
      r = 32'h7FFF_FFFF;
    end else if (v[35] && (v[34:31] != 4'hF)) begin
      r = 32'h8000_0000;
    end
    return r;
  endfunction

  // Observation differences against the stored position.
  logic [32:0] dx_full, dy_full, dx_mag, dy_mag;
  logic        dx_neg, dy_neg;
  assign dx_full = {obs_x_q[31], obs_x_q} - {est_x_q[31], est_x_q};
  assign dy_full = {obs_y_q[31], obs_y_q} - {est_y_q[31], est_y_q};
  assign dx_neg  = dx_full[32];
  assign dy_neg  = dy_full[32];
  assign dx_mag  = dx_neg ? (33'd0 - dx_full) : dx_full;
  assign dy_mag  = dy_neg ? (33'd0 - dy_full) : dy_full;

  logic [31:0] old_v, old_mag, vx_mag, vy_mag;
  assign old_v   = ax_q ? est_vy_q : est_vx_q;
  assign old_mag = old_v[31] ? (32'd0 - old_v) : old_v;
  assign vx_mag  = est_vx_q[31] ? (32'd0 - est_vx_q) : est_vx_q;
  assign vy_mag  = est_vy_q[31] ? (32'd0 - est_vy_q) : est_vy_q;

  // Raw velocity: clamp the quotient, then saturate on the positive side.
  logic [31:0] raw_clamp;
  always_comb begin
    raw_clamp = (div_rsp.quot[63:31] != '0) ? 32'h8000_0000 : div_rsp.quot[31:0];
    if (!(ax_q ? dy_neg : dx_neg) && raw_clamp[31]) begin
      raw_clamp = 32'h7FFF_FFFF;
    end
  end

  // EMA rounding, ties away from zero.
  logic [49:0] num_mag;
  logic [33:0] num_rnd;
  logic [31:0] ema_v;
  always_comb begin
    num_mag = num_q[49] ? (50'd0 - num_q) : num_q;
    num_rnd = 34'((num_mag + 50'd32768) >> 16);
    if (!num_q[49]) begin
      ema_v = (num_rnd > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : num_rnd[31:0];
    end else begin
      ema_v = (num_rnd > 34'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - num_rnd[31:0]);
    end
  end

  // Square root, two radicand bits per cycle.
  logic [34:0] sq_ext, sq_trial;
  logic        sq_ge;
  logic [31:0] sq_root_d;
  assign sq_ext    = {sq_rem_q, sq_v_q[63:62]};
  assign sq_trial  = {1'b0, sq_root_q, 2'b01};
  assign sq_ge     = sq_ext >= sq_trial;
  assign sq_root_d = {sq_root_q[30:0], sq_ge};

  logic [32:0] unc_sum;
  assign unc_sum = {1'b0, unc_base_q} + {1'b0, mul_rsp.prod[47:16]};

  logic [31:0] speed_d;
  logic [32:0] s_plus_v;
  assign speed_d  = s_q - div_rsp.quot[31:0];
  assign s_plus_v = {1'b0, s_q} + {1'b0, speed_d};

  // Component of a magnitude along the stored direction.
  logic [31:0] comp_v, comp_mag;
  logic [63:0] comp_m;
  logic [33:0] comp_q;
  logic [34:0] comp_s;
  logic [31:0] comp_est;
  logic [35:0] comp_pos;
  assign comp_v   = cidx_q[0] ? est_vy_q : est_vx_q;
  assign comp_mag = cidx_q[0] ? vy_mag : vx_mag;
  assign comp_m   = cidx_q[1] ? {32'd0, speed_q} : dist_q;
  assign comp_q   = (div_rsp.quot > 64'h2_0000_0000) ? 34'h2_0000_0000
                                                      : div_rsp.quot[33:0];
  assign comp_s   = comp_v[31] ? (35'd0 - {1'b0, comp_q}) : {1'b0, comp_q};
  assign comp_est = cidx_q[0] ? est_y_q : est_x_q;
  assign comp_pos = {{4{comp_est[31]}}, comp_est} + {comp_s[34], comp_s};

  // A serial unit's start is registered: it is set at the clock edge on which its state is left.
  always_comb begin
    mul_start_d = 1'b0;
    div_start_d = 1'b0;
    case (state_q)
      ST_OB_START: mul_start_d = (stamp_q > est_time_q);
      ST_OB_MULD:  div_start_d = mul_rsp.done;
      ST_OB_DIV:   mul_start_d = div_rsp.done;
      ST_OB_MULW:  mul_start_d = mul_rsp.done;
      ST_OB_RND:   mul_start_d = !ax_q;
      ST_QY_START: mul_start_d = 1'b1;
      ST_QY_SQX:   mul_start_d = mul_rsp.done;
      ST_QY_SQRT:  mul_start_d = (sq_cnt_q == 5'd0);
      ST_QY_UNC:   mul_start_d = mul_rsp.done && (s_q != '0);
      ST_QY_MST:   div_start_d = mul_rsp.done;
      ST_QY_DST:   mul_start_d = div_rsp.done;
      ST_QY_MSS:   div_start_d = mul_rsp.done;
      ST_QY_MAT:   div_start_d = mul_rsp.done;
      ST_QY_DAT:   mul_start_d = div_rsp.done;
      ST_QY_MTS:   div_start_d = mul_rsp.done;
      ST_QY_CL:    mul_start_d = 1'b1;
      ST_QY_MCMP:  div_start_d = mul_rsp.done;
      default: begin
        mul_start_d = 1'b0;
        div_start_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= 16'd3277;
      decel_q     <= 21'd11764;
      unc_base_q  <= 32'd131072;
      unc_slope_q <= 16'd32768;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgWeight:   weight_q    <= cfg_data_i[15:0];
        CfgDecel:    decel_q     <= cfg_data_i[20:0];
        CfgUncBase:  unc_base_q  <= cfg_data_i;
        CfgUncSlope: unc_slope_q <= cfg_data_i[15:0];
        default:     weight_q    <= weight_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      est_x_q     <= '0;
      est_y_q     <= '0;
      est_vx_q    <= '0;
      est_vy_q    <= '0;
      est_time_q  <= '0;
      kind_q      <= 1'b0;
      stamp_q     <= '0;
      obs_x_q     <= '0;
      obs_y_q     <= '0;
      ax_q        <= 1'b0;
      dt_q        <= '0;
      raw_neg_q   <= 1'b0;
      p1_q        <= '0;
      p2_q        <= '0;
      num_q       <= '0;
      sq_q        <= '0;
      sq_v_q      <= '0;
      sq_rem_q    <= '0;
      sq_root_q   <= '0;
      sq_cnt_q    <= '0;
      s_q         <= '0;
      t_q         <= '0;
      a_q         <= '0;
      speed_q     <= '0;
      dist_q      <= '0;
      cidx_q      <= '0;
      unc_q       <= '0;
      res_x_q     <= '0;
      res_y_q     <= '0;
      res_vx_q    <= '0;
      res_vy_q    <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_vx_q    <= '0;
      out_vy_q    <= '0;
      out_unc_q   <= '0;
      out_stamp_q <= '0;
      mul_req_q   <= '0;
      div_req_q   <= '0;
    end else begin
      mul_req_q.start <= mul_start_d;
      div_req_q.start <= div_start_d;
      if (out_valid_q && out_ready_i && (state_q != ST_QY_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= kind_i;
            stamp_q <= stamp_us_i;
            obs_x_q <= obs_x_i;
            obs_y_q <= obs_y_i;
            state_q <= kind_i ? ST_QY_START : ST_OB_START;
          end
        end
        ST_OB_START: begin
          if (stamp_q > est_time_q) begin
            dt_q             <= stamp_q - est_time_q;
            ax_q             <= 1'b0;
            mul_req_q.mcand  <= {31'd0, dx_mag};
            mul_req_q.mplier <= {UsPerS, 13'd0};
            mul_req_q.nbits  <= 6'd20;
            state_q          <= ST_OB_MULD;
          end else begin
            est_x_q    <= obs_x_q;
            est_y_q    <= obs_y_q;
            est_time_q <= stamp_q;
            state_q    <= ST_IDLE;
          end
        end
        ST_OB_MULD: begin
          if (mul_rsp.done) begin
            div_req_q.dividend <= {mul_rsp.prod[52:0], 43'd0};
            div_req_q.divisor  <= dt_q;
            div_req_q.nbits    <= 7'd53;
            state_q            <= ST_OB_DIV;
          end
        end
        ST_OB_DIV: begin
          if (div_rsp.done) begin
            raw_neg_q        <= ax_q ? dy_neg : dx_neg;
            mul_req_q.mcand  <= {32'd0, raw_clamp};
            mul_req_q.mplier <= {weight_q, 17'd0};
            mul_req_q.nbits  <= 6'd16;
            state_q          <= ST_OB_MULW;
          end
        end
        ST_OB_MULW: begin
          if (mul_rsp.done) begin
            p1_q             <= mul_rsp.prod[47:0];
            mul_req_q.mcand  <= {32'd0, old_mag};
            mul_req_q.mplier <= {17'h1_0000 - {1'b0, weight_q}, 16'd0};
            mul_req_q.nbits  <= 6'd17;
            state_q          <= ST_OB_MULO;
          end
        end
        ST_OB_MULO: begin
          if (mul_rsp.done) begin
            p2_q    <= mul_rsp.prod[48:0];
            state_q <= ST_OB_SUM;
          end
        end
        ST_OB_SUM: begin
          num_q   <= (raw_neg_q ? (50'd0 - {2'b0, p1_q}) : {2'b0, p1_q})
                   + (old_v[31] ? (50'd0 - {1'b0, p2_q}) : {1'b0, p2_q});
          state_q <= ST_OB_RND;
        end
        ST_OB_RND: begin
          if (!ax_q) begin
            est_vx_q         <= ema_v;
            ax_q             <= 1'b1;
            mul_req_q.mcand  <= {31'd0, dy_mag};
            mul_req_q.mplier <= {UsPerS, 13'd0};
            mul_req_q.nbits  <= 6'd20;
            state_q          <= ST_OB_MULD;
          end else begin
            est_vy_q   <= ema_v;
            est_x_q    <= obs_x_q;
            est_y_q    <= obs_y_q;
            est_time_q <= stamp_q;
            state_q    <= ST_IDLE;
          end
        end
        ST_QY_START: begin
          t_q              <= (stamp_q > est_time_q) ? (stamp_q - est_time_q) : 48'd0;
          a_q              <= (decel_q != '0) ? decel_q : 21'd1;
          mul_req_q.mcand  <= {32'd0, vx_mag};
          mul_req_q.mplier <= {vx_mag, 1'b0};
          mul_req_q.nbits  <= 6'd32;
          state_q          <= ST_QY_SQX;
        end
        ST_QY_SQX: begin
          if (mul_rsp.done) begin
            sq_q             <= mul_rsp.prod[63:0];
            mul_req_q.mcand  <= {32'd0, vy_mag};
            mul_req_q.mplier <= {vy_mag, 1'b0};
            mul_req_q.nbits  <= 6'd32;
            state_q          <= ST_QY_SQY;
          end
        end
        ST_QY_SQY: begin
          if (mul_rsp.done) begin
            sq_v_q    <= sq_q + mul_rsp.prod[63:0];
            sq_rem_q  <= '0;
            sq_root_q <= '0;
            sq_cnt_q  <= 5'd31;
            state_q   <= ST_QY_SQRT;
          end
        end
        ST_QY_SQRT: begin
          sq_v_q    <= {sq_v_q[61:0], 2'b00};
          sq_rem_q  <= sq_ge ? 33'(sq_ext - sq_trial) : sq_ext[32:0];
          sq_root_q <= sq_root_d;
          sq_cnt_q  <= sq_cnt_q - 1'b1;
          if (sq_cnt_q == 5'd0) begin
            s_q              <= sq_root_d;
            mul_req_q.mcand  <= {32'd0, sq_root_d};
            mul_req_q.mplier <= {unc_slope_q, 17'd0};
            mul_req_q.nbits  <= 6'd16;
            state_q          <= ST_QY_UNC;
          end
        end
        ST_QY_UNC: begin
          if (mul_rsp.done) begin
            unc_q <= unc_sum[32] ? 32'hFFFF_FFFF : unc_sum[31:0];
            if (s_q == '0) begin
              res_x_q  <= est_x_q;
              res_y_q  <= est_y_q;
              res_vx_q <= '0;
              res_vy_q <= '0;
              state_q  <= ST_QY_OUT;
            end else begin
              mul_req_q.mcand  <= {32'd0, s_q};
              mul_req_q.mplier <= {UsPerS, 13'd0};
              mul_req_q.nbits  <= 6'd20;
              state_q          <= ST_QY_MST;
            end
          end
        end
        ST_QY_MST: begin
          if (mul_rsp.done) begin
            div_req_q.dividend <= {mul_rsp.prod[51:0], 44'd0};
            div_req_q.divisor  <= {27'd0, a_q};
            div_req_q.nbits    <= 7'd52;
            state_q            <= ST_QY_DST;
          end
        end
        ST_QY_DST: begin
          if (div_rsp.done) begin
            if ({16'd0, t_q} >= div_rsp.quot) begin
              // The object has come to rest before the query time.
              speed_q          <= '0;
              mul_req_q.mcand  <= {32'd0, s_q};
              mul_req_q.mplier <= {s_q, 1'b0};
              mul_req_q.nbits  <= 6'd32;
              state_q          <= ST_QY_MSS;
            end else begin
              mul_req_q.mcand  <= {16'd0, t_q};
              mul_req_q.mplier <= {a_q, 12'd0};
              mul_req_q.nbits  <= 6'd21;
              state_q          <= ST_QY_MAT;
            end
          end
        end
        ST_QY_MSS: begin
          if (mul_rsp.done) begin
            div_req_q.dividend <= {mul_rsp.prod[63:0], 32'd0};
            div_req_q.divisor  <= {26'd0, a_q, 1'b0};
            div_req_q.nbits    <= 7'd64;
            state_q            <= ST_QY_DSS;
          end
        end
        ST_QY_DSS: begin
          if (div_rsp.done) begin
            dist_q  <= div_rsp.quot;
            cidx_q  <= '0;
            state_q <= ST_QY_CL;
          end
        end
        ST_QY_MAT: begin
          if (mul_rsp.done) begin
            div_req_q.dividend <= {mul_rsp.prod[68:0], 27'd0};
            div_req_q.divisor  <= {28'd0, UsPerS};
            div_req_q.nbits    <= 7'd69;
            state_q            <= ST_QY_DAT;
          end
        end
        ST_QY_DAT: begin
          if (div_rsp.done) begin
            speed_q          <= speed_d;
            mul_req_q.mcand  <= {16'd0, t_q};
            mul_req_q.mplier <= s_plus_v;
            mul_req_q.nbits  <= 6'd33;
            state_q          <= ST_QY_MTS;
          end
        end
        ST_QY_MTS: begin
          if (mul_rsp.done) begin
            div_req_q.dividend <= {mul_rsp.prod[80:0], 15'd0};
            div_req_q.divisor  <= {27'd0, UsPer2S};
            div_req_q.nbits    <= 7'd81;
            state_q            <= ST_QY_DTS;
          end
        end
        ST_QY_DTS: begin
          if (div_rsp.done) begin
            dist_q  <= div_rsp.quot;
            cidx_q  <= '0;
            state_q <= ST_QY_CL;
          end
        end
        ST_QY_CL: begin
          mul_req_q.mcand  <= comp_m;
          mul_req_q.mplier <= {comp_mag, 1'b0};
          mul_req_q.nbits  <= 6'd32;
          state_q          <= ST_QY_MCMP;
        end
        ST_QY_MCMP: begin
          if (mul_rsp.done) begin
            div_req_q.dividend <= mul_rsp.prod[95:0];
            div_req_q.divisor  <= {16'd0, s_q};
            div_req_q.nbits    <= 7'd96;
            state_q            <= ST_QY_DCMP;
          end
        end
        ST_QY_DCMP: begin
          if (div_rsp.done) begin
            case (cidx_q)
              2'd0:    res_x_q  <= sat_s36(comp_pos);
              2'd1:    res_y_q  <= sat_s36(comp_pos);
              2'd2:    res_vx_q <= sat_s36({comp_s[34], comp_s});
              default: res_vy_q <= sat_s36({comp_s[34], comp_s});
            endcase
            cidx_q  <= cidx_q + 1'b1;
            state_q <= (cidx_q == 2'd3) ? ST_QY_OUT : ST_QY_CL;
          end
        end
        ST_QY_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_x_q     <= res_x_q;
            out_y_q     <= res_y_q;
            out_vx_q    <= res_vx_q;
            out_vy_q    <= res_vy_q;
            out_unc_q   <= unc_q;
            out_stamp_q <= stamp_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o             = (state_q == ST_IDLE);
  assign out_valid_o            = out_valid_q;
  assign pred_x_o               = out_x_q;
  assign pred_y_o               = out_y_q;
  assign pred_vx_o              = out_vx_q;
  assign pred_vy_o              = out_vy_q;
  assign velocity_uncertainty_o = out_unc_q;
  assign pred_stamp_us_o        = out_stamp_q;

`ifndef NO_ASSERTIONS
  a_idle_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!mul_req_q.start && !div_req_q.start))
    else $error("serial unit started while idle");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("accepted word did not start work");

  a_zero_speed_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_QY_OUT) && (s_q == '0)) |-> ((res_vx_q == '0) && (res_vy_q == '0)))
    else $error("zero speed gave nonzero velocity");

  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_QY_OUT) && ($past(kind_q) == 1'b1))
    else $error("result word not produced by a query");
`endif

endmodule
